// ===== hw/rtl/azb_pkg.sv =====
// Shared types, constants and trigonometric threshold tables of the azimuth binner.
`default_nettype none

package azb_pkg;

    localparam int CELL_W    = 7;
    localparam int BIN_W     = 9;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // The degree floor inside one octant lies in 0..44 and is found one bit a stage.
    localparam int FL_W     = 6;
    localparam int TAB_N    = 64;
    localparam int DEG_LAST = 44;
    localparam int DEG_DIAG = 45;
    localparam int DEG_COMP = 89;

    // Fractional bits of the sine and cosine thresholds.
    localparam int TRIG_W = 40;
    localparam int HALF_W = TRIG_W / 2;

    localparam int OFF_Q1    = 10;
    localparam int OFF_Q23   = 190;
    localparam int OFF_Q4    = 370;
    localparam int FULL_TURN = 360;
    localparam int NO_BIN    = 0;

    localparam logic [1:0] QUAD_1  = 2'd0;
    localparam logic [1:0] QUAD_23 = 2'd1;
    localparam logic [1:0] QUAD_4  = 2'd2;

    localparam real PI_R = 3.14159265358979323846;

    typedef struct packed {
        logic       zero;
        logic       exact;
        logic       swap;
        logic       same;
        logic [1:0] quad;
    } azb_ctrl_t;

    typedef logic [TRIG_W-1:0] trig_tab_t [TAB_N];

    // Converts a real value in [0, 1) to an unsigned fraction of TRIG_W bits, in two halves.
    function automatic logic [TRIG_W-1:0] real_to_q(input real v);
        real         scale;
        real         s;
        real         r;
        logic [31:0] hi;
        logic [31:0] lo;
        scale = 2.0 ** HALF_W;
        s     = v * scale;
        hi    = 32'($rtoi(s));
        r     = (s - real'(hi)) * scale;
        lo    = 32'($rtoi(r));
        return {hi[HALF_W-1:0], lo[HALF_W-1:0]};
    endfunction

    // Entries beyond the last threshold make the comparison fail.
    function automatic trig_tab_t build_tab(input logic want_sin);
        trig_tab_t t;
        real       ang;
        int        d;
        for (d = 0; d < TAB_N; d++) begin
            if (d > DEG_LAST || d == 0) begin
                t[d] = want_sin ? '1 : '0;
            end else begin
                ang  = real'(d) * PI_R / 180.0;
                t[d] = real_to_q(want_sin ? $sin(ang) : $cos(ang));
            end
        end
        return t;
    endfunction

    localparam trig_tab_t SIN_TAB = build_tab(1'b1);
    localparam trig_tab_t COS_TAB = build_tab(1'b0);

endpackage

`default_nettype wire

// ===== hw/rtl/azb_prep.sv =====
// Input stage: centres the cell, folds it into the first octant and records the quadrant.
`default_nettype none

module azb_prep
    import azb_pkg::*;
#(
    parameter int GRID_SIZE = 100,
    parameter int MAG_W     = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [CELL_W-1:0]    in_x,
    input  wire logic [CELL_W-1:0]    in_y,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [MAG_W-1:0]          out_num,
    output logic [MAG_W-1:0]          out_den,
    output azb_ctrl_t                 out_ctrl
);

    localparam int OFF_W = MAG_W + 1;
    localparam int G1    = GRID_SIZE + 1;

    logic signed [OFF_W-1:0] dx;
    logic signed [OFF_W-1:0] dy;
    logic [MAG_W-1:0]        ax;
    logic [MAG_W-1:0]        ay;

    logic             valid_reg;
    logic             valid_next;
    logic [MAG_W-1:0] num_reg;
    logic [MAG_W-1:0] num_next;
    logic [MAG_W-1:0] den_reg;
    logic [MAG_W-1:0] den_next;
    azb_ctrl_t        ctrl_reg;
    azb_ctrl_t        ctrl_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        dx = $signed({{(OFF_W-CELL_W-1){1'b0}}, in_x, 1'b0}) - $signed(OFF_W'(G1));
        dy = $signed({{(OFF_W-CELL_W-1){1'b0}}, in_y, 1'b0}) - $signed(OFF_W'(G1));
        ax = dx[OFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
        ay = dy[OFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);

        ctrl_next.zero  = (dx == '0) || (dy == '0);
        ctrl_next.exact = (ax == ay);
        ctrl_next.swap  = (ay > ax);
        ctrl_next.same  = (dx[OFF_W-1] == dy[OFF_W-1]);
        if (!dx[OFF_W-1] && dx != '0) begin
            ctrl_next.quad = dy[OFF_W-1] ? QUAD_4 : QUAD_1;
        end else begin
            ctrl_next.quad = QUAD_23;
        end

        // The smaller magnitude becomes the numerator so the angle stays at or below 45 degrees.
        num_next   = ctrl_next.swap ? ax : ay;
        den_next   = ctrl_next.swap ? ay : ax;
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            ctrl_reg <= ctrl_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_ctrl  = ctrl_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/azb_search_stage.sv =====
// One stage of the binary search for the whole-degree floor of the octant angle.
`default_nettype none

module azb_search_stage
    import azb_pkg::*;
#(
    parameter int MAG_W = 8,
    parameter int BIT   = 5
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [MAG_W-1:0]     in_num,
    input  wire logic [MAG_W-1:0]     in_den,
    input  wire azb_ctrl_t            in_ctrl,
    input  wire logic [FL_W-1:0]      in_fl,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [MAG_W-1:0]          out_num,
    output logic [MAG_W-1:0]          out_den,
    output azb_ctrl_t                 out_ctrl,
    output logic [FL_W-1:0]           out_fl
);

    localparam int PROD_W = MAG_W + TRIG_W;

    logic [FL_W-1:0]   cand;
    logic [PROD_W-1:0] prod_n;
    logic [PROD_W-1:0] prod_d;

    logic             valid_reg;
    logic             valid_next;
    logic [MAG_W-1:0] num_reg;
    logic [MAG_W-1:0] den_reg;
    azb_ctrl_t        ctrl_reg;
    logic [FL_W-1:0]  fl_reg;
    logic [FL_W-1:0]  fl_next;

    assign in_ready = !valid_reg || out_ready;

    // num/den exceeds tan(cand) exactly when num*cos(cand) exceeds den*sin(cand).
    always_comb begin
        cand       = in_fl;
        cand[BIT]  = 1'b1;
        prod_n     = PROD_W'(in_num) * PROD_W'(COS_TAB[cand]);
        prod_d     = PROD_W'(in_den) * PROD_W'(SIN_TAB[cand]);
        fl_next    = (prod_n > prod_d) ? cand : in_fl;
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            num_reg  <= in_num;
            den_reg  <= in_den;
            ctrl_reg <= in_ctrl;
            fl_reg   <= fl_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_fl    = fl_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/azb_bin.sv =====
// Output stage: unfolds the octant floor, adds the quadrant offset and wraps to a bin.
`default_nettype none

module azb_bin
    import azb_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire azb_ctrl_t            in_ctrl,
    input  wire logic [FL_W-1:0]      in_fl,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [BIN_W-1:0]          out_bin
);

    logic [6:0]        fl_full;
    logic signed [7:0] th;
    logic [BIN_W-1:0]  off;
    logic [9:0]        v;
    logic [BIN_W-1:0]  wrapped;

    logic             valid_reg;
    logic             valid_next;
    logic [BIN_W-1:0] bin_reg;
    logic [BIN_W-1:0] bin_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        if (in_ctrl.exact) begin
            fl_full = 7'(DEG_DIAG);
        end else if (in_ctrl.swap) begin
            fl_full = 7'(DEG_COMP) - 7'(in_fl);
        end else begin
            fl_full = 7'(in_fl);
        end

        // With opposite signs the angle is negative, and its floor is one lower
        // unless it is a whole number of degrees, which only the diagonal gives.
        if (in_ctrl.same) begin
            th = $signed({1'b0, fl_full});
        end else if (in_ctrl.exact) begin
            th = -8'sd45;
        end else begin
            th = -$signed({1'b0, fl_full}) - 8'sd1;
        end

        case (in_ctrl.quad)
            QUAD_1:  off = BIN_W'(OFF_Q1);
            QUAD_4:  off = BIN_W'(OFF_Q4);
            default: off = BIN_W'(OFF_Q23);
        endcase

        v       = 10'({1'b0, off}) + 10'($unsigned(10'(th)));
        wrapped = (v >= 10'(FULL_TURN)) ? BIN_W'(v - 10'(FULL_TURN)) : BIN_W'(v);
        bin_next = in_ctrl.zero ? BIN_W'(NO_BIN) : wrapped + 1'b1;
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            bin_reg <= bin_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_bin   = bin_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/grid_cell_to_azimuth_bin.sv =====
// Top level of the azimuth binner: maps a crystal grid cell to a one-degree azimuth bin.
//
// The slave channel carries one grid cell per transaction, x_cell in s_tdata[6:0] and
// y_cell in s_tdata[13:7]. The master channel returns one transaction per cell with
// azimuth_bin, 1 to 360, in m_tdata[8:0]; a cell whose centred offset is zero, which only
// an odd GRID_SIZE allows, returns 0.
// The pipeline has eight register stages: a centring and octant fold, six stages of a
// binary search that each settle one bit of the degree floor by comparing num*cos
// against den*sin of a tabled threshold, and the quadrant offset and wrap. One cell is
// taken every cycle while no stall on m_tready backs up the pipeline.
// Each stage has its own valid bit and loads whenever it is empty or its successor
// loads, so a stall on m_tready only holds the stages that are full; cells are still
// taken while bubbles remain, and nothing is lost or repeated.
// Reset empties every stage; no results are offered until new cells arrive.
`default_nettype none

module grid_cell_to_azimuth_bin
    import azb_pkg::*;
#(
    parameter int GRID_SIZE = 100
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,  // [6:0] x_cell, [13:7] y_cell
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata   // [8:0] azimuth_bin
);

    localparam int G1      = GRID_SIZE + 1;
    localparam int MAG_MAX = (G1 > 254) ? G1 : 254;
    localparam int MAG_W   = $clog2(MAG_MAX + 1);

    logic             vld_s  [0:FL_W];
    logic             rdy_s  [0:FL_W];
    logic [MAG_W-1:0] num_s  [0:FL_W-1];
    logic [MAG_W-1:0] den_s  [0:FL_W-1];
    azb_ctrl_t        ctrl_s [0:FL_W];
    logic [FL_W-1:0]  fl_s   [0:FL_W];
    logic [BIN_W-1:0] bin;

    assign fl_s[0] = '0;

    azb_prep #(
        .GRID_SIZE (GRID_SIZE),
        .MAG_W     (MAG_W)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      (s_tdata[CELL_W-1:0]),
        .in_y      (s_tdata[2*CELL_W-1:CELL_W]),
        .out_valid (vld_s[0]),
        .out_ready (rdy_s[0]),
        .out_num   (num_s[0]),
        .out_den   (den_s[0]),
        .out_ctrl  (ctrl_s[0])
    );

    for (genvar g = 0; g < FL_W; g++) begin : g_search
        if (g < FL_W - 1) begin : g_mid
            azb_search_stage #(
                .MAG_W (MAG_W),
                .BIT   (FL_W - 1 - g)
            ) u_stage (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (vld_s[g]),
                .in_ready  (rdy_s[g]),
                .in_num    (num_s[g]),
                .in_den    (den_s[g]),
                .in_ctrl   (ctrl_s[g]),
                .in_fl     (fl_s[g]),
                .out_valid (vld_s[g+1]),
                .out_ready (rdy_s[g+1]),
                .out_num   (num_s[g+1]),
                .out_den   (den_s[g+1]),
                .out_ctrl  (ctrl_s[g+1]),
                .out_fl    (fl_s[g+1])
            );
        end else begin : g_last
            azb_search_stage #(
                .MAG_W (MAG_W),
                .BIT   (FL_W - 1 - g)
            ) u_stage (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (vld_s[g]),
                .in_ready  (rdy_s[g]),
                .in_num    (num_s[g]),
                .in_den    (den_s[g]),
                .in_ctrl   (ctrl_s[g]),
                .in_fl     (fl_s[g]),
                .out_valid (vld_s[g+1]),
                .out_ready (rdy_s[g+1]),
                .out_num   (),
                .out_den   (),
                .out_ctrl  (ctrl_s[g+1]),
                .out_fl    (fl_s[g+1])
            );
        end
    end

    azb_bin u_bin (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld_s[FL_W]),
        .in_ready  (rdy_s[FL_W]),
        .in_ctrl   (ctrl_s[FL_W]),
        .in_fl     (fl_s[FL_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_bin   (bin)
    );

    assign m_tdata = {{(M_TDATA_W-BIN_W){1'b0}}, bin};

    // The search never settles above the last tabled threshold.
    a_fl_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_s[FL_W] |-> (fl_s[FL_W] <= FL_W'(DEG_LAST)))
        else $error("degree floor beyond the last threshold");

    a_bin_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (bin <= BIN_W'(FULL_TURN)))
        else $error("azimuth bin above 360");

    // An even grid never centres a cell on an axis, so no error code can appear.
    a_no_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        ((GRID_SIZE % 2) == 0) && m_tvalid |-> (bin != BIN_W'(NO_BIN)))
        else $error("zero bin from an even grid");

    // With the output register free, every stage can move, so input must be taken.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the output register is empty");

endmodule

`default_nettype wire
